### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the box-pair overlap test.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define OBB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under an active-low reset.
`define OBB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/obb_sat_pkg.sv
// Package for the box-pair separating-axis test: word types, register codes
// and field helpers. Depends on nothing.
`default_nettype none
package obb_sat_pkg;

  localparam int unsigned FieldW = 20;
  localparam int unsigned RegW   = 60;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned Latency = 9;
  localparam logic [3:0]  NoAxis  = 4'd15;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgARot0 = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgARot1 = 4'd1;
  localparam logic [CfgIdxW-1:0] CfgARot2 = 4'd2;
  localparam logic [CfgIdxW-1:0] CfgAOff  = 4'd3;
  localparam logic [CfgIdxW-1:0] CfgBRot0 = 4'd4;
  localparam logic [CfgIdxW-1:0] CfgBRot1 = 4'd5;
  localparam logic [CfgIdxW-1:0] CfgBRot2 = 4'd6;
  localparam logic [CfgIdxW-1:0] CfgBOff  = 4'd7;

  // Identity rotation rows, Q3.16
  localparam logic [RegW-1:0] RotRow0Rst = 60'd65536;
  localparam logic [RegW-1:0] RotRow1Rst = 60'd65536 << 20;
  localparam logic [RegW-1:0] RotRow2Rst = 60'd65536 << 40;

  typedef struct packed {
    logic [RegW-1:0] a_center;
    logic [RegW-1:0] a_axis_x;
    logic [RegW-1:0] a_axis_y;
    logic [RegW-1:0] a_axis_z;
    logic [RegW-1:0] a_half_extents;
    logic [RegW-1:0] b_center;
    logic [RegW-1:0] b_axis_x;
    logic [RegW-1:0] b_axis_y;
    logic [RegW-1:0] b_axis_z;
    logic [RegW-1:0] b_half_extents;
  } in_word_t;

  typedef struct packed {
    logic       collide;
    logic [3:0] separating_axis;
  } out_word_t;

  // Pick signed 20-bit field k of a packed triple
  function automatic logic signed [19:0] fld(input logic [RegW-1:0] v,
                                             input int unsigned k);
    fld = signed'(v[FieldW*k +: FieldW]);
  endfunction

  // Two's-complement magnitude, modulo 2^64
  function automatic logic [63:0] mag64(input logic [63:0] v);
    mag64 = v[63] ? (64'd0 - v) : v;
  endfunction

endpackage
`default_nettype wire

### rtl/core/obb_pair_separating_axis_test.sv
// Top level of the 15-axis oriented-box overlap test, nine register stages.
// Depends on obb_sat_pkg and assert_macros.svh.
//
//  channel  | direction | handshake             | word
//  ---------+-----------+-----------------------+---------------------------
//  command  | in        | start_i / busy_o      | in_word_i  (in_word_t)
//  result   | out       | res_valid_o strobe    | result_o   (out_word_t)
//  config   | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One word enters per cycle; busy_o stays low. Each result is registered
// through the nine stages (rotate, sum, cross, shift, dot partials, dot sum,
// extent partials, compare, encode).
// Reset clears the valid bits and loads identity rotations, zero offsets.
// The result strobe lasts one cycle; the receiver takes every result.
`default_nettype none
`include "assert_macros.svh"
module obb_pair_separating_axis_test (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire obb_sat_pkg::in_word_t         in_word_i,
  output logic                               res_valid_o,
  output obb_sat_pkg::out_word_t             result_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [obb_sat_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [obb_sat_pkg::RegW-1:0]  cfg_data_i
);

  // Configuration registers: [0]=A, [1]=B
  logic [obb_sat_pkg::RegW-1:0] rot_q [2][3];
  logic [obb_sat_pkg::RegW-1:0] off_q [2];

  logic [obb_sat_pkg::Latency-1:0] v_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Write configuration; drop indexes beyond the list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < 2; b++) begin
        rot_q[b][0] <= obb_sat_pkg::RotRow0Rst;
        rot_q[b][1] <= obb_sat_pkg::RotRow1Rst;
        rot_q[b][2] <= obb_sat_pkg::RotRow2Rst;
        off_q[b]    <= '0;
      end
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        obb_sat_pkg::CfgARot0: rot_q[0][0] <= cfg_data_i;
        obb_sat_pkg::CfgARot1: rot_q[0][1] <= cfg_data_i;
        obb_sat_pkg::CfgARot2: rot_q[0][2] <= cfg_data_i;
        obb_sat_pkg::CfgAOff:  off_q[0]    <= cfg_data_i;
        obb_sat_pkg::CfgBRot0: rot_q[1][0] <= cfg_data_i;
        obb_sat_pkg::CfgBRot1: rot_q[1][1] <= cfg_data_i;
        obb_sat_pkg::CfgBRot2: rot_q[1][2] <= cfg_data_i;
        obb_sat_pkg::CfgBOff:  off_q[1]    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[obb_sat_pkg::Latency-2:0], start_i && !busy_o};
    end
  end

  // ---------------- stage 1: rotation products ----------------
  // vectors 0 A center, 1-3 A axes, 4 B center, 5-7 B axes
  logic [obb_sat_pkg::RegW-1:0] vec [8];
  logic signed [39:0] p1_d [8][3][3];
  logic signed [39:0] p1_q [8][3][3];
  logic signed [19:0] ext1_d [6];
  logic signed [19:0] ext1_q [6], ext2_q [6], ext3_q [6], ext4_q [6];
  logic signed [19:0] ext5_q [6], ext6_q [6];

  always_comb begin
    vec[0] = in_word_i.a_center;
    vec[1] = in_word_i.a_axis_x;
    vec[2] = in_word_i.a_axis_y;
    vec[3] = in_word_i.a_axis_z;
    vec[4] = in_word_i.b_center;
    vec[5] = in_word_i.b_axis_x;
    vec[6] = in_word_i.b_axis_y;
    vec[7] = in_word_i.b_axis_z;
    for (int n = 0; n < 8; n++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p1_d[n][i][j] = obb_sat_pkg::fld(rot_q[n / 4][i], j)
                        * obb_sat_pkg::fld(vec[n], j);
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      ext1_d[i]     = obb_sat_pkg::fld(in_word_i.a_half_extents, i);
      ext1_d[3 + i] = obb_sat_pkg::fld(in_word_i.b_half_extents, i);
    end
  end

  // ---------------- stage 2: world centers and axes ----------------
  logic signed [41:0] r2 [8][3];
  logic signed [26:0] c2 [2][3];
  logic signed [25:0] w2_d [6][3];
  logic signed [27:0] t2_d [3];
  logic signed [25:0] w2_q [6][3], w3_q [6][3], w4_q [6][3];
  logic signed [27:0] t2_q [3], t3_q [3], t4_q [3];

  always_comb begin
    for (int n = 0; n < 8; n++) begin
      for (int i = 0; i < 3; i++) begin
        r2[n][i] = 42'(p1_q[n][i][0]) + 42'(p1_q[n][i][1]) + 42'(p1_q[n][i][2]);
      end
    end
    for (int b = 0; b < 2; b++) begin
      for (int i = 0; i < 3; i++) begin
        c2[b][i] = 27'(signed'(r2[4 * b][i][41:16]))
                 + 27'(obb_sat_pkg::fld(off_q[b], i));
        for (int a = 0; a < 3; a++) begin
          w2_d[3 * b + a][i] = r2[4 * b + 1 + a][i][41:16];
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      t2_d[i] = 28'(c2[1][i]) - 28'(c2[0][i]);
    end
  end

  // ---------------- stage 3: cross products ----------------
  // per pair: y*z', z*y', z*x', x*z', x*y', y*x'
  logic signed [51:0] cp3_d [9][6];
  logic signed [51:0] cp3_q [9][6];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        cp3_d[3 * i + j][0] = w2_q[i][1] * w2_q[3 + j][2];
        cp3_d[3 * i + j][1] = w2_q[i][2] * w2_q[3 + j][1];
        cp3_d[3 * i + j][2] = w2_q[i][2] * w2_q[3 + j][0];
        cp3_d[3 * i + j][3] = w2_q[i][0] * w2_q[3 + j][2];
        cp3_d[3 * i + j][4] = w2_q[i][0] * w2_q[3 + j][1];
        cp3_d[3 * i + j][5] = w2_q[i][1] * w2_q[3 + j][0];
      end
    end
  end

  // ---------------- stage 4: candidate axes ----------------
  logic signed [52:0] df4 [9][3];
  logic signed [36:0] l4_d [15][3];
  logic signed [36:0] l4_q [15][3];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      for (int i = 0; i < 3; i++) begin
        l4_d[k][i] = 37'(w3_q[k][i]);
      end
    end
    for (int m = 0; m < 9; m++) begin
      for (int i = 0; i < 3; i++) begin
        df4[m][i] = 53'(cp3_q[m][2 * i]) - 53'(cp3_q[m][2 * i + 1]);
        l4_d[6 + m][i] = df4[m][i][52:16];
      end
    end
  end

  // ---------------- stage 5: dot partial products ----------------
  // split each axis entry into a signed high part and an unsigned low part
  logic signed [20:0] lh5 [15][3];
  logic signed [16:0] ll5 [15][3];
  logic signed [48:0] th5_d [15][3];
  logic signed [44:0] tl5_d [15][3];
  logic signed [46:0] wh5_d [15][6][3];
  logic signed [42:0] wl5_d [15][6][3];
  logic signed [48:0] th5_q [15][3];
  logic signed [44:0] tl5_q [15][3];
  logic signed [46:0] wh5_q [15][6][3];
  logic signed [42:0] wl5_q [15][6][3];

  always_comb begin
    for (int k = 0; k < 15; k++) begin
      for (int i = 0; i < 3; i++) begin
        lh5[k][i] = l4_q[k][i][36:16];
        ll5[k][i] = signed'({1'b0, l4_q[k][i][15:0]});
        th5_d[k][i] = t4_q[i] * lh5[k][i];
        tl5_d[k][i] = t4_q[i] * ll5[k][i];
        for (int n = 0; n < 6; n++) begin
          wh5_d[k][n][i] = w4_q[n][i] * lh5[k][i];
          wl5_d[k][n][i] = w4_q[n][i] * ll5[k][i];
        end
      end
    end
  end

  // ---------------- stage 6: dot sums, left side, projections ----------------
  logic [63:0] dt6 [15];
  logic [63:0] dw6 [15][6];
  logic [63:0] lhs6_d [15];
  logic signed [47:0] pj6_d [15][6];
  logic [63:0] lhs6_q [15], lhs7_q [15];
  logic signed [47:0] pj6_q [15][6];

  always_comb begin
    for (int k = 0; k < 15; k++) begin
      dt6[k] = '0;
      for (int i = 0; i < 3; i++) begin
        dt6[k] = dt6[k] + (64'(th5_q[k][i]) << 16) + 64'(tl5_q[k][i]);
      end
      lhs6_d[k] = obb_sat_pkg::mag64(dt6[k]);
      for (int n = 0; n < 6; n++) begin
        dw6[k][n] = '0;
        for (int i = 0; i < 3; i++) begin
          dw6[k][n] = dw6[k][n] + (64'(wh5_q[k][n][i]) << 16) + 64'(wl5_q[k][n][i]);
        end
        pj6_d[k][n] = signed'(dw6[k][n][63:16]);
      end
    end
  end

  // ---------------- stage 7: extent partial products ----------------
  logic signed [43:0] eh7_d [15][6];
  logic signed [44:0] el7_d [15][6];
  logic signed [43:0] eh7_q [15][6];
  logic signed [44:0] el7_q [15][6];

  always_comb begin
    for (int k = 0; k < 15; k++) begin
      for (int n = 0; n < 6; n++) begin
        eh7_d[k][n] = ext6_q[n] * signed'(pj6_q[k][n][47:24]);
        el7_d[k][n] = ext6_q[n] * signed'({1'b0, pj6_q[k][n][23:0]});
      end
    end
  end

  // ---------------- stage 8: right side and compare ----------------
  logic [63:0] rhs8 [15];
  logic [14:0] sep8_d;
  logic [14:0] sep8_q;

  always_comb begin
    for (int k = 0; k < 15; k++) begin
      rhs8[k] = '0;
      for (int n = 0; n < 6; n++) begin
        rhs8[k] = rhs8[k] + obb_sat_pkg::mag64((64'(eh7_q[k][n]) << 24)
                                               + 64'(el7_q[k][n]));
      end
      sep8_d[k] = lhs7_q[k] > rhs8[k];
    end
  end

  // ---------------- stage 9: first separating axis ----------------
  obb_sat_pkg::out_word_t res9_d;

  always_comb begin
    res9_d.collide         = 1'b1;
    res9_d.separating_axis = obb_sat_pkg::NoAxis;
    for (int k = 14; k >= 0; k--) begin
      if (sep8_q[k]) begin
        res9_d.collide         = 1'b0;
        res9_d.separating_axis = 4'(k);
      end
    end
  end

  // Hold stage payloads (no reset)
  always_ff @(posedge clk_i) begin
    p1_q   <= p1_d;
    ext1_q <= ext1_d;
    w2_q   <= w2_d;
    t2_q   <= t2_d;
    ext2_q <= ext1_q;
    cp3_q  <= cp3_d;
    w3_q   <= w2_q;
    t3_q   <= t2_q;
    ext3_q <= ext2_q;
    l4_q   <= l4_d;
    w4_q   <= w3_q;
    t4_q   <= t3_q;
    ext4_q <= ext3_q;
    th5_q  <= th5_d;
    tl5_q  <= tl5_d;
    wh5_q  <= wh5_d;
    wl5_q  <= wl5_d;
    ext5_q <= ext4_q;
    lhs6_q <= lhs6_d;
    pj6_q  <= pj6_d;
    ext6_q <= ext5_q;
    eh7_q  <= eh7_d;
    el7_q  <= el7_d;
    lhs7_q <= lhs6_q;
    sep8_q <= sep8_d;
    result_o <= res9_d;
  end

  assign res_valid_o = v_q[obb_sat_pkg::Latency-1];

  // Checks
  `OBB_ASSERT_IMP(a_latency, clk_i, rst_ni, start_i && !busy_o, ##9 res_valid_o,
    "accepted word did not produce a result after nine cycles")
  `OBB_ASSERT_IMP(a_no_spurious, clk_i, rst_ni, !$past(start_i, 9), !res_valid_o,
    "result without a matching command")
  `OBB_ASSERT_IMP(a_axis_code, clk_i, rst_ni, res_valid_o,
    result_o.collide == (result_o.separating_axis == obb_sat_pkg::NoAxis),
    "collide flag disagrees with axis code")

endmodule
`default_nettype wire

### tb/obb_pair_separating_axis_test_test.sv
// Testbench for the 15-axis oriented-box overlap test: drives box pairs and
// register writes, predicts each collide/axis word and checks every result.
// Depends on obb_sat_pkg and the obb_pair_separating_axis_test RTL.
`default_nettype none
module obb_pair_separating_axis_test_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 400;
  localparam int unsigned NumBoxRegs = 8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  obb_sat_pkg::in_word_t in_word_i = '0;
  logic res_valid_o;
  obb_sat_pkg::out_word_t result_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [obb_sat_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [obb_sat_pkg::RegW-1:0] cfg_data_i = '0;

  logic [obb_sat_pkg::RegW-1:0] box_frame[NumBoxRegs];
  obb_sat_pkg::out_word_t overlap_due[$];
  int unsigned pairs_taken = 0;
  int unsigned writes_taken = 0;
  int unsigned quiet_cycles = 0;
  int unsigned idle_pct = 0;
  bit mismatch = 1'b0;

  obb_pair_separating_axis_test uut (
    .clk_i, .rst_ni, .start_i, .busy_o, .in_word_i, .res_valid_o, .result_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // Signed 20-bit field k of a packed triple
  function automatic longint sfield(input logic [obb_sat_pkg::RegW-1:0] v, input int k);
    logic signed [19:0] f;
    f = v[20*k +: 20];
    return longint'(f);
  endfunction

  function automatic logic [obb_sat_pkg::RegW-1:0] pack3(input int x, input int y,
                                                         input int z);
    logic [19:0] fx, fy, fz;
    fx = x[19:0];
    fy = y[19:0];
    fz = z[19:0];
    return {fz, fy, fx};
  endfunction

  // Product of rotation rows at base and a packed vector, full precision
  function automatic void rotate_vec(input int base, input logic [obb_sat_pkg::RegW-1:0] v,
                                     output longint r[3]);
    for (int i = 0; i < 3; i++) begin
      r[i] = 0;
      for (int j = 0; j < 3; j++)
        r[i] += sfield(box_frame[base + i], j) * sfield(v, j);
    end
  endfunction

  function automatic obb_sat_pkg::out_word_t overlap_of(input obb_sat_pkg::in_word_t w);
    longint ca[3], cb[3], t[3], wax[6][3], ext[6], ax[15][3], r[3];
    logic [obb_sat_pkg::RegW-1:0] axes_in[6];
    logic [63:0] lhs, rhs, prod;
    longint d, proj;
    int hit;
    obb_sat_pkg::out_word_t o;
    axes_in = '{w.a_axis_x, w.a_axis_y, w.a_axis_z, w.b_axis_x, w.b_axis_y, w.b_axis_z};
    rotate_vec(0, w.a_center, ca);
    rotate_vec(4, w.b_center, cb);
    for (int i = 0; i < 3; i++) begin
      ca[i] = (ca[i] >>> 16) + sfield(box_frame[obb_sat_pkg::CfgAOff], i);
      cb[i] = (cb[i] >>> 16) + sfield(box_frame[obb_sat_pkg::CfgBOff], i);
      t[i] = cb[i] - ca[i];
      ext[i] = sfield(w.a_half_extents, i);
      ext[3 + i] = sfield(w.b_half_extents, i);
    end
    for (int k = 0; k < 6; k++) begin
      rotate_vec(k < 3 ? 0 : 4, axes_in[k], r);
      for (int i = 0; i < 3; i++) begin
        wax[k][i] = r[i] >>> 16;
        ax[k][i] = wax[k][i];
      end
    end
    // true cross products, A axis i x B axis j
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        ax[6+3*i+j][0] = (wax[i][1]*wax[3+j][2] - wax[i][2]*wax[3+j][1]) >>> 16;
        ax[6+3*i+j][1] = (wax[i][2]*wax[3+j][0] - wax[i][0]*wax[3+j][2]) >>> 16;
        ax[6+3*i+j][2] = (wax[i][0]*wax[3+j][1] - wax[i][1]*wax[3+j][0]) >>> 16;
      end
    hit = int'(obb_sat_pkg::NoAxis);
    for (int k = 0; k < 15 && hit == obb_sat_pkg::NoAxis; k++) begin
      d = t[0]*ax[k][0] + t[1]*ax[k][1] + t[2]*ax[k][2];
      lhs = d[63] ? 64'd0 - d : d;
      rhs = 0;
      for (int b = 0; b < 6; b++) begin
        proj = (wax[b][0]*ax[k][0] + wax[b][1]*ax[k][1] + wax[b][2]*ax[k][2]) >>> 16;
        prod = ext[b] * proj;
        rhs += prod[63] ? 64'd0 - prod : prod;
      end
      if (lhs > rhs) hit = k;
    end
    o.collide = (hit == obb_sat_pkg::NoAxis);
    o.separating_axis = hit[3:0];
    return o;
  endfunction

  // Track register writes, predict accepted pairs, check results
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_frame = '{obb_sat_pkg::RotRow0Rst, obb_sat_pkg::RotRow1Rst,
                    obb_sat_pkg::RotRow2Rst, '0,
                    obb_sat_pkg::RotRow0Rst, obb_sat_pkg::RotRow1Rst,
                    obb_sat_pkg::RotRow2Rst, '0};
    end else begin
      quiet_cycles++;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i < NumBoxRegs) box_frame[cfg_index_i] = cfg_data_i;
        writes_taken++;
        quiet_cycles = 0;
      end
      if (start_i && !busy_o) begin
        overlap_due.push_back(overlap_of(in_word_i));
        pairs_taken++;
        quiet_cycles = 0;
      end
      if (res_valid_o) begin
        quiet_cycles = 0;
        if (overlap_due.size() == 0) begin
          $display("%0t: unexpected word collide=%0d axis=%0d", $time,
                   result_o.collide, result_o.separating_axis);
          mismatch = 1'b1;
        end else begin
          obb_sat_pkg::out_word_t e;
          e = overlap_due.pop_front();
          if (e.collide !== result_o.collide) begin
            $display("%0t: collide expected %0d actual %0d", $time, e.collide,
                     result_o.collide);
            mismatch = 1'b1;
          end
          if (e.separating_axis !== result_o.separating_axis) begin
            $display("%0t: axis expected %0d actual %0d", $time,
                     e.separating_axis, result_o.separating_axis);
            mismatch = 1'b1;
          end
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    if (quiet_cycles >= StallLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Send one box pair, then idle at random
  task automatic send_pair(input obb_sat_pkg::in_word_t w);
    int unsigned n;
    n = pairs_taken;
    start_i <= 1'b1;
    in_word_i <= w;
    wait (pairs_taken != n);
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain;
    start_i <= 1'b0;
    wait (overlap_due.size() == 0);
    repeat (obb_sat_pkg::Latency + 3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [obb_sat_pkg::CfgIdxW-1:0] idx,
                           input logic [obb_sat_pkg::RegW-1:0] val);
    int unsigned n;
    n = writes_taken;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    wait (writes_taken != n);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic int srand(input int lim);
    return int'($urandom_range(2 * lim)) - lim;
  endfunction

  function automatic logic [obb_sat_pkg::RegW-1:0] rand_word();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[obb_sat_pkg::RegW-1:0];
  endfunction

  // Near-unit axes, small centers and extents, some negative extents; a quarter are fully random words
  function automatic obb_sat_pkg::in_word_t rand_pair();
    obb_sat_pkg::in_word_t w;
    if ($urandom_range(99) < 25) return {rand_word(), rand_word(), rand_word(),
        rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
        rand_word(), rand_word()};
    w.a_center = pack3(srand(1500), srand(1500), srand(1500));
    w.b_center = pack3(srand(1500), srand(1500), srand(1500));
    w.a_axis_x = pack3(srand(65536), srand(65536), srand(65536));
    w.a_axis_y = pack3(srand(65536), srand(65536), srand(65536));
    w.a_axis_z = pack3(srand(65536), srand(65536), srand(65536));
    w.b_axis_x = pack3(srand(65536), srand(65536), srand(65536));
    w.b_axis_y = pack3(srand(65536), srand(65536), srand(65536));
    w.b_axis_z = pack3(srand(65536), srand(65536), srand(65536));
    w.a_half_extents = pack3(srand(900), srand(900), srand(900));
    w.b_half_extents = pack3($urandom_range(900), $urandom_range(900), $urandom_range(900));
    return w;
  endfunction

  function automatic obb_sat_pkg::in_word_t axis_pair(input int bx, input int ea,
                                                      input int eb);
    obb_sat_pkg::in_word_t w;
    w.a_center = '0;
    w.b_center = pack3(bx, 0, 0);
    w.a_axis_x = pack3(65536, 0, 0);
    w.a_axis_y = pack3(0, 65536, 0);
    w.a_axis_z = pack3(0, 0, 65536);
    w.b_axis_x = w.a_axis_x;
    w.b_axis_y = w.a_axis_y;
    w.b_axis_z = w.a_axis_z;
    w.a_half_extents = pack3(ea, ea, ea);
    w.b_half_extents = pack3(eb, eb, eb);
    return w;
  endfunction

  // Identity frames: ties, separation, parallel crosses, extremes of fields
  task automatic test_directed;
    obb_sat_pkg::in_word_t w;
    idle_pct = 0;
    send_pair(axis_pair(512, 256, 256));
    send_pair(axis_pair(513, 256, 256));
    send_pair(axis_pair(-513, 256, 256));
    send_pair(axis_pair(513, -256, -256));
    send_pair(axis_pair(0, 0, 0));
    send_pair('0);
    send_pair('1);
    send_pair({10{pack3(-524288, -524288, -524288)}});
    send_pair({10{pack3(524287, 524287, 524287)}});
    w = axis_pair(0, 100, 100);
    w.b_center = pack3(0, 150, 170);
    send_pair(w);
    w.b_axis_x = pack3(46341, 46341, 0);
    w.b_axis_y = pack3(-46341, 46341, 0);
    send_pair(w);
    w.b_center = pack3(300, 300, 0);
    send_pair(w);
    w.a_axis_x = pack3(131072, 0, 0);
    send_pair(w);
    drain();
  endtask

  // Ignored indexes, then all registers at extremes
  task automatic test_register_extremes;
    idle_pct = 23;
    for (int i = NumBoxRegs; i < 16; i++) write_reg(i[obb_sat_pkg::CfgIdxW-1:0], '1);
    for (int i = 0; i < 40; i++) send_pair(rand_pair());
    drain();
    for (int i = 0; i < NumBoxRegs; i++) write_reg(i[obb_sat_pkg::CfgIdxW-1:0], '1);
    for (int i = 0; i < 40; i++) send_pair(rand_pair());
    drain();
    for (int i = 0; i < NumBoxRegs; i++)
      write_reg(i[obb_sat_pkg::CfgIdxW-1:0], {3{20'h80000}});
    for (int i = 0; i < 40; i++) send_pair(rand_pair());
    drain();
    for (int i = 0; i < NumBoxRegs; i++) write_reg(i[obb_sat_pkg::CfgIdxW-1:0], '0);
    for (int i = 0; i < 30; i++) send_pair(rand_pair());
    drain();
  endtask

  // Identity frames in the first phase, random frames after, with varying sender idling
  task automatic test_random_pairs;
    int unsigned pct[4] = '{0, 64, 23, 0};
    logic [obb_sat_pkg::RegW-1:0] rows[2][3];
    logic [obb_sat_pkg::RegW-1:0] offs[2];
    for (int ph = 0; ph < 8; ph++) begin
      idle_pct = pct[ph % 4];
      for (int b = 0; b < 2; b++) begin
        if (ph == 0) begin
          rows[b][0] = obb_sat_pkg::RotRow0Rst;
          rows[b][1] = obb_sat_pkg::RotRow1Rst;
          rows[b][2] = obb_sat_pkg::RotRow2Rst;
          offs[b] = '0;
        end else begin
          for (int i = 0; i < 3; i++)
            rows[b][i] = (ph == 7) ? rand_word()
                         : pack3(srand(65536), srand(65536), srand(65536));
          offs[b] = pack3(srand(2000), srand(2000), srand(2000));
        end
      end
      write_reg(obb_sat_pkg::CfgARot0, rows[0][0]);
      write_reg(obb_sat_pkg::CfgARot1, rows[0][1]);
      write_reg(obb_sat_pkg::CfgARot2, rows[0][2]);
      write_reg(obb_sat_pkg::CfgAOff, offs[0]);
      write_reg(obb_sat_pkg::CfgBRot0, rows[1][0]);
      write_reg(obb_sat_pkg::CfgBRot1, rows[1][1]);
      write_reg(obb_sat_pkg::CfgBRot2, rows[1][2]);
      write_reg(obb_sat_pkg::CfgBOff, offs[1]);
      for (int i = 0; i < 150; i++) send_pair(rand_pair());
      drain();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_register_extremes();
    test_random_pairs();
    if (!mismatch) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire
